[rtl/bpva_pkg.sv]
`default_nettype none
package bpva_pkg;

    localparam int MAX_POINTS_DEF = 8;

    // Working width of the value, first and second derivative lanes.
    // Holds the largest second derivative for up to 32 points with margin.
    localparam int WORK_W = 56;
    localparam int T_W    = 17;
    localparam int PROD_W = WORK_W + T_W + 1;
    localparam int POS_W  = 32;
    localparam int DER_W  = 48;
    localparam int CNT_W  = 4;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    typedef logic signed [WORK_W-1:0] t_work;

    typedef struct packed {
        t_work v;
        t_work d;
        t_work a;
    } t_node;

    // Round half up and drop the 16 fraction bits of a product with t.
    function automatic t_work round_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = (p + PROD_W'(32768)) >>> 16;
        return s[WORK_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input t_work x);
        logic [POS_W-1:0] r;
        if (x > t_work'(64'sh7FFF_FFFF)) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else if (x < -t_work'(64'sh8000_0000)) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = x[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DER_W-1:0] sat_der(input t_work x);
        logic [DER_W-1:0] r;
        if (x > t_work'(64'sh7FFF_FFFF_FFFF)) begin
            r = {1'b0, {(DER_W-1){1'b1}}};
        end else if (x < -t_work'(64'sh8000_0000_0000)) begin
            r = {1'b1, {(DER_W-1){1'b0}}};
        end else begin
            r = x[DER_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/bezier_pos_vel_acc_eval_unit.sv]
`default_nettype none
// Bezier evaluator with first and second derivatives.
// Input channel (i_valid / o_stall): a load transaction (i_kind = 0) writes one
// control point into slot i_point_index; an evaluate transaction (i_kind = 1)
// evaluates the curve at i_t_fraction (Q1.16) over the first point_count points.
// Output channel (o_valid / i_stall): one transaction per evaluate, none per load.
// o_ok is low, with all other fields zero, when point_count is zero or t is above 1.0.
// point_count is written through i_cfg_we / i_cfg_data; the user must do so only while
// the block is idle, as the block itself does not enforce it. A load does not stall
// the input. An evaluate runs de Casteljau reduction one node at a time through a
// working memory, each coordinate in turn, with a read, modify, write of each node.
// An invalid evaluate skips the reduction. The block takes no new transaction
// while an evaluate is in flight. If the receiver stalls, the finished result waits
// in the output register; a following evaluate is accepted but holds its result
// until the earlier one has been taken.
// Reset clears point_count and the output valid. Control points are undefined until
// they are loaded.
module bezier_pos_vel_acc_eval_unit #(
    parameter int MAX_POINTS = bpva_pkg::MAX_POINTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_kind,
    input  wire  [2:0]                   i_point_index,
    input  wire  signed [31:0]           i_coord_x,
    input  wire  signed [31:0]           i_coord_y,
    input  wire  signed [31:0]           i_coord_z,
    input  wire  [bpva_pkg::T_W-1:0]     i_t_fraction,
    input  wire                          i_cfg_we,
    input  wire  [bpva_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic                         o_ok,
    output logic signed [31:0]           o_pos_x,
    output logic signed [31:0]           o_pos_y,
    output logic signed [31:0]           o_pos_z,
    output logic signed [47:0]           o_vel_x,
    output logic signed [47:0]           o_vel_y,
    output logic signed [47:0]           o_vel_z,
    output logic signed [47:0]           o_acc_x,
    output logic signed [47:0]           o_acc_y,
    output logic signed [47:0]           o_acc_z
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CP_RD  = 4'd1;
    localparam logic [3:0] S_CP_WR  = 4'd2;
    localparam logic [3:0] S_L_RA   = 4'd3;
    localparam logic [3:0] S_L_WA   = 4'd4;
    localparam logic [3:0] S_L_CALC = 4'd5;
    localparam logic [3:0] S_L_WB   = 4'd6;
    localparam logic [3:0] S_F_RD   = 4'd7;
    localparam logic [3:0] S_F_WR   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]                 r_state;
    logic [bpva_pkg::CNT_W-1:0] r_count;
    logic [CW-1:0]              r_n;
    logic [CW-1:0]              r_i;
    logic [CW-1:0]              r_lvl;
    logic [1:0]                 r_c;
    logic [bpva_pkg::T_W-1:0]   r_t;
    logic                       r_ok;
    logic                       r_o_valid;

    logic [95:0]                pt_mem [MAX_POINTS];
    logic [95:0]                r_pt_q;
    logic [AW-1:0]              pt_raddr;
    logic                       pt_we;

    bpva_pkg::t_node            wk_mem [MAX_POINTS];
    bpva_pkg::t_node            r_wk_q;
    bpva_pkg::t_node            wk_wdata;
    logic [AW-1:0]              wk_raddr;
    logic                       wk_we;

    bpva_pkg::t_node            r_prev;
    bpva_pkg::t_node            r_cur;
    bpva_pkg::t_work            r_dv;
    bpva_pkg::t_work            r_dd;
    logic signed [bpva_pkg::PROD_W-1:0] r_pv;
    logic signed [bpva_pkg::PROD_W-1:0] r_pd;
    logic signed [bpva_pkg::PROD_W-1:0] r_pa;

    logic [bpva_pkg::POS_W-1:0] r_pos [3];
    logic [bpva_pkg::DER_W-1:0] r_vel [3];
    logic [bpva_pkg::DER_W-1:0] r_acc [3];

    logic                       in_acc;
    logic                       out_acc;
    logic [CW-1:0]              n_eval;
    logic [CW-1:0]              i_plus1;
    logic [CW-1:0]              i_plus2;
    logic [CW-1:0]              lvl_plus1;
    logic signed [31:0]         coord_sel;
    bpva_pkg::t_work            dv;
    bpva_pkg::t_work            dd;
    bpva_pkg::t_work            da;
    logic signed [bpva_pkg::PROD_W-1:0] t_ext;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

    assign i_plus1   = r_i + CW'(1);
    assign i_plus2   = r_i + CW'(2);
    assign lvl_plus1 = r_lvl + CW'(1);

    always_comb begin
        if (32'(r_count) > 32'(MAX_POINTS)) begin
            n_eval = CW'(MAX_POINTS);
        end else begin
            n_eval = CW'(r_count);
        end
    end

    // Control point store.
    assign pt_we    = in_acc && (i_kind == bpva_pkg::KIND_LOAD)
                      && ({29'd0, i_point_index} < 32'(MAX_POINTS));
    assign pt_raddr = r_i[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[AW'(i_point_index)] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        r_pt_q <= pt_mem[pt_raddr];
    end

    always_comb begin
        unique case (r_c)
            2'd0:    coord_sel = r_pt_q[31:0];
            2'd1:    coord_sel = r_pt_q[63:32];
            default: coord_sel = r_pt_q[95:64];
        endcase
    end

    // Working node store.
    always_comb begin
        wk_we    = 1'b0;
        wk_wdata = r_prev;
        wk_raddr = r_i[AW-1:0];
        unique case (r_state)
            S_CP_WR: begin
                wk_we      = 1'b1;
                wk_wdata.v = bpva_pkg::WORK_W'(coord_sel);
                wk_wdata.d = '0;
                wk_wdata.a = '0;
            end
            S_L_WA: begin
                wk_raddr = i_plus1[AW-1:0];
            end
            S_L_WB: begin
                wk_we      = 1'b1;
                wk_wdata.v = r_prev.v + bpva_pkg::round_q16(r_pv);
                wk_wdata.d = r_prev.d + bpva_pkg::round_q16(r_pd) + r_dv;
                wk_wdata.a = r_prev.a + bpva_pkg::round_q16(r_pa) + (r_dd <<< 1);
                wk_raddr   = i_plus2[AW-1:0];
            end
            S_F_RD: begin
                wk_raddr = '0;
            end
            default: begin
                wk_raddr = r_i[AW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wk_we) begin
            wk_mem[r_i[AW-1:0]] <= wk_wdata;
        end
        r_wk_q <= wk_mem[wk_raddr];
    end

    // Differences of a neighbor pair and their products with t.
    assign dv    = r_wk_q.v - r_prev.v;
    assign dd    = r_wk_q.d - r_prev.d;
    assign da    = r_wk_q.a - r_prev.a;
    assign t_ext = bpva_pkg::PROD_W'(r_t);

    always_ff @(posedge i_clk) begin
        if (r_state == S_L_WA) begin
            r_prev <= r_wk_q;
        end else if (r_state == S_L_WB) begin
            r_prev <= r_cur;
        end
        if (r_state == S_L_CALC) begin
            r_cur <= r_wk_q;
            r_dv  <= dv;
            r_dd  <= dd;
            r_pv  <= bpva_pkg::PROD_W'(dv) * t_ext;
            r_pd  <= bpva_pkg::PROD_W'(dd) * t_ext;
            r_pa  <= bpva_pkg::PROD_W'(da) * t_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_kind == bpva_pkg::KIND_EVAL) begin
            r_t <= i_t_fraction;
            r_n <= n_eval;
        end
        if (r_state == S_F_WR) begin
            r_pos[r_c] <= bpva_pkg::sat_pos(r_wk_q.v);
            r_vel[r_c] <= bpva_pkg::sat_der(r_wk_q.d);
            r_acc[r_c] <= bpva_pkg::sat_der(r_wk_q.a);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_i       <= '0;
            r_lvl     <= '0;
            r_c       <= '0;
            r_ok      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (out_acc) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind == bpva_pkg::KIND_EVAL) begin
                        r_i <= '0;
                        r_c <= '0;
                        if (n_eval == '0 || i_t_fraction > bpva_pkg::T_ONE) begin
                            r_ok    <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_ok    <= 1'b1;
                            r_state <= S_CP_RD;
                        end
                    end
                end
                S_CP_RD: begin
                    r_state <= S_CP_WR;
                end
                S_CP_WR: begin
                    if (i_plus1 == r_n) begin
                        r_i   <= '0;
                        r_lvl <= CW'(1);
                        r_state <= (r_n == CW'(1)) ? S_F_RD : S_L_RA;
                    end else begin
                        r_i     <= i_plus1;
                        r_state <= S_CP_RD;
                    end
                end
                S_L_RA: begin
                    r_state <= S_L_WA;
                end
                S_L_WA: begin
                    r_state <= S_L_CALC;
                end
                S_L_CALC: begin
                    r_state <= S_L_WB;
                end
                S_L_WB: begin
                    if (i_plus1 < r_n - r_lvl) begin
                        r_i     <= i_plus1;
                        r_state <= S_L_CALC;
                    end else begin
                        r_i <= '0;
                        if (lvl_plus1 < r_n) begin
                            r_lvl   <= lvl_plus1;
                            r_state <= S_L_RA;
                        end else begin
                            r_state <= S_F_RD;
                        end
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_WR;
                end
                S_F_WR: begin
                    r_i <= '0;
                    if (r_c == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_c     <= r_c + 2'd1;
                        r_state <= S_CP_RD;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register, loaded when the finished result moves out.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_o_valid || !i_stall)) begin
            o_ok <= r_ok;
            if (r_ok) begin
                o_pos_x <= r_pos[0];
                o_pos_y <= r_pos[1];
                o_pos_z <= r_pos[2];
                o_vel_x <= r_vel[0];
                o_vel_y <= r_vel[1];
                o_vel_z <= r_vel[2];
                o_acc_x <= r_acc[0];
                o_acc_y <= r_acc[1];
                o_acc_z <= r_acc[2];
            end else begin
                o_pos_x <= '0;
                o_pos_y <= '0;
                o_pos_z <= '0;
                o_vel_x <= '0;
                o_vel_y <= '0;
                o_vel_z <= '0;
                o_acc_x <= '0;
                o_acc_y <= '0;
                o_acc_z <= '0;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/bpva_check.sv]
`default_nettype none
module bpva_check (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_stall,
    input wire               i_kind,
    input wire               o_valid,
    input wire               i_stall,
    input wire               o_ok,
    input wire signed [31:0] o_pos_x,
    input wire signed [47:0] o_vel_x,
    input wire signed [47:0] o_acc_x
);

    // A stalled result transaction stays on the port.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x))
        else $error("stalled result dropped or changed");

    // An invalid evaluation carries zero fields.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_pos_x == 0 && o_vel_x == 0 && o_acc_x == 0)
        else $error("invalid result with nonzero fields");

    // An accepted evaluate keeps the input side stalled in the next cycle.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_kind |=> o_stall)
        else $error("input taken during an evaluation");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind bezier_pos_vel_acc_eval_unit bpva_check u_bpva_check (.*);
`default_nettype wire
